[sv/bdcq_pkg.sv]
package bdcq_pkg;

	localparam int TIME_W     = 32;
	localparam int POLL_W     = 10;
	localparam int MS_W       = 16;
	localparam int IDX_W      = 2;
	localparam int RAW_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERPRESS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_INDEX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROFILE_INDEX = 3'd5;

	localparam logic [POLL_W-1:0] POLL_PERIOD_RST   = 10'd20;
	localparam logic [MS_W-1:0]   DEBOUNCE_RST      = 16'd50;
	localparam logic [MS_W-1:0]   INTERPRESS_RST    = 16'd200;
	localparam logic [MS_W-1:0]   LONG_PRESS_RST    = 16'd3000;
	localparam logic [IDX_W-1:0]  MODE_INDEX_RST    = 2'd0;
	localparam logic [IDX_W-1:0]  PROFILE_INDEX_RST = 2'd1;

	// combo tracker view for this tick, before the release check on fired
	typedef struct packed {
		logic tracking;
		logic fired;
		logic hit;
	} combo_gate_t;

endpackage

[sv/bdcq_lane.sv]
module bdcq_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       raw_down,
	input  logic [bdcq_pkg::TIME_W-1:0] now_n,
	input  logic [bdcq_pkg::MS_W-1:0]   debounce,
	input  logic [bdcq_pkg::MS_W-1:0]   interpress,
	input  logic                       allow,
	input  logic                       fire_on_release,
	output logic                       stable_nxt,
	output logic                       fire
);
	import bdcq_pkg::*;

	logic              last_raw_q;
	logic              stable_q;
	logic [TIME_W-1:0] change_q;
	logic [TIME_W-1:0] fire_time_q;
	logic [TIME_W-1:0] change_n;
	logic              edge_seen;
	logic              lock_ok;

	always_comb begin
		change_n   = (raw_down != last_raw_q) ? now_n : change_q;
		stable_nxt = ((raw_down != stable_q) && ((now_n - change_n) >= TIME_W'(debounce)))
			? raw_down : stable_q;
	end

	always_comb begin
		edge_seen  = fire_on_release ? (stable_q && !stable_nxt) : (stable_nxt && !stable_q);
		lock_ok    = (now_n - fire_time_q) >= TIME_W'(interpress);
		fire       = allow && edge_seen && lock_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b0;
			stable_q    <= 1'b0;
			change_q    <= '0;
			fire_time_q <= '0;
		end else if (advance) begin
			last_raw_q <= raw_down;
			change_q   <= change_n;
			stable_q   <= stable_nxt;
			if (fire) begin
				fire_time_q <= now_n;
			end
		end
	end

endmodule

[sv/bdcq_combo.sv]
module bdcq_combo #(
	parameter int BUTTONS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [BUTTONS-1:0]          stable_nxt,
	input  logic [bdcq_pkg::TIME_W-1:0] now_n,
	input  logic [bdcq_pkg::MS_W-1:0]   long_press,
	input  logic [bdcq_pkg::IDX_W-1:0]  mode_idx,
	input  logic [bdcq_pkg::IDX_W-1:0]  profile_idx,
	output logic [BUTTONS-1:0]          mode_sel,
	output logic [BUTTONS-1:0]          profile_sel,
	output bdcq_pkg::combo_gate_t       gate
);
	import bdcq_pkg::*;

	logic              tracking_q;
	logic              fired_q;
	logic [TIME_W-1:0] start_q;
	logic              tracking_n;
	logic              fired_mid;
	logic              fired_n;
	logic [TIME_W-1:0] start_n;
	logic              mode_on;
	logic              profile_on;
	logic              hit;

	always_comb begin
		mode_on    = 1'b0;
		profile_on = 1'b0;
		for (int i = 0; i < BUTTONS; i++) begin
			mode_sel[i]    = (32'(mode_idx) == 32'(i));
			profile_sel[i] = (32'(profile_idx) == 32'(i));
			mode_on        = mode_on | (stable_nxt[i] & mode_sel[i]);
			profile_on     = profile_on | (stable_nxt[i] & profile_sel[i]);
		end

		tracking_n = tracking_q;
		fired_mid  = fired_q;
		start_n    = start_q;
		hit        = 1'b0;
		if (!(mode_on && profile_on)) begin
			tracking_n = 1'b0;
		end else if (!tracking_q) begin
			tracking_n = 1'b1;
			fired_mid  = 1'b0;
			start_n    = now_n;
		end else if (!fired_q && ((now_n - start_q) >= TIME_W'(long_press))) begin
			fired_mid = 1'b1;
			hit       = 1'b1;
		end
		// drop the block once both combo buttons are released
		fired_n = fired_mid && (mode_on || profile_on);

		gate.tracking = tracking_n;
		gate.fired    = fired_mid;
		gate.hit      = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			fired_q    <= 1'b0;
			start_q    <= '0;
		end else if (advance) begin
			tracking_q <= tracking_n;
			fired_q    <= fired_n;
			start_q    <= start_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit |=> tracking_q && fired_q)
		else $error("combo fired without tracking state set");

endmodule

[sv/button_debounce_combo_qualifier_core.sv]
// Pipeline: the input register loads at the input transfer, and the result register
// loads when that tick advances, which waits while a held result is not taken.
// Throughput: one tick per cycle; the input stalls only while both registers hold a
// tick and the result waits at the output.
// Reset clears time, all button and combo state and both pipeline valids, and puts
// the configuration registers at their defaults.
module button_debounce_combo_qualifier_core #(
	parameter int BUTTONS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bdcq_pkg::RAW_W-1:0]      raw_levels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bdcq_pkg::RAW_W-1:0]      press_events,
	output logic                            combo_event,
	output logic [bdcq_pkg::RAW_W-1:0]      stable_levels,
	input  logic                            cfg_we,
	input  logic [bdcq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdcq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdcq_pkg::*;

	localparam int EXT_W = (BUTTONS > RAW_W) ? BUTTONS : RAW_W;

	logic [POLL_W-1:0] poll_q;
	logic [MS_W-1:0]   debounce_q;
	logic [MS_W-1:0]   interpress_q;
	logic [MS_W-1:0]   long_press_q;
	logic [IDX_W-1:0]  mode_idx_q;
	logic [IDX_W-1:0]  profile_idx_q;

	logic              valid_s1;
	logic [RAW_W-1:0]  raw_s1;
	logic              valid_s2;
	logic [RAW_W-1:0]  events_s2;
	logic              combo_s2;
	logic [RAW_W-1:0]  levels_s2;

	logic              advance;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] now_n;

	logic [BUTTONS-1:0] raw_down;
	logic [BUTTONS-1:0] stable_nxt;
	logic [BUTTONS-1:0] fire;
	logic [BUTTONS-1:0] allow;
	logic [BUTTONS-1:0] mode_sel;
	logic [BUTTONS-1:0] profile_sel;
	combo_gate_t        gate;
	logic [EXT_W-1:0]   fire_ext;
	logic [EXT_W-1:0]   stable_ext;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign now_n     = now_q + TIME_W'(poll_q);
	assign fire_ext   = EXT_W'(fire);
	assign stable_ext = EXT_W'(stable_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q        <= POLL_PERIOD_RST;
			debounce_q    <= DEBOUNCE_RST;
			interpress_q  <= INTERPRESS_RST;
			long_press_q  <= LONG_PRESS_RST;
			mode_idx_q    <= MODE_INDEX_RST;
			profile_idx_q <= PROFILE_INDEX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLL_PERIOD:   poll_q        <= cfg_data[POLL_W-1:0];
				REG_DEBOUNCE:      debounce_q    <= cfg_data[MS_W-1:0];
				REG_INTERPRESS:    interpress_q  <= cfg_data[MS_W-1:0];
				REG_LONG_PRESS:    long_press_q  <= cfg_data[MS_W-1:0];
				REG_MODE_INDEX:    mode_idx_q    <= cfg_data[IDX_W-1:0];
				REG_PROFILE_INDEX: profile_idx_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			now_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				now_q    <= now_n;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_levels;
		end
		if (advance) begin
			events_s2 <= fire_ext[RAW_W-1:0];
			combo_s2  <= gate.hit;
			levels_s2 <= stable_ext[RAW_W-1:0];
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < BUTTONS; gi++) begin : g_lane
			if (gi < RAW_W) begin : g_wired
				assign raw_down[gi] = !raw_s1[gi];
			end else begin : g_absent
				assign raw_down[gi] = 1'b0;
			end

			// profile button fires on release; all are blocked while the combo is tracked, profile and mode also once it fired
			assign allow[gi] = profile_sel[gi] ? (!gate.tracking && !gate.fired)
				: (!gate.tracking && !(gate.fired && mode_sel[gi]));

			bdcq_lane u_lane (
				.clk            (clk),
				.arst_n         (arst_n),
				.advance        (advance),
				.raw_down       (raw_down[gi]),
				.now_n          (now_n),
				.debounce       (debounce_q),
				.interpress     (interpress_q),
				.allow          (allow[gi]),
				.fire_on_release(profile_sel[gi]),
				.stable_nxt     (stable_nxt[gi]),
				.fire           (fire[gi])
			);
		end
	endgenerate

	bdcq_combo #(
		.BUTTONS(BUTTONS)
	) u_combo (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.stable_nxt (stable_nxt),
		.now_n      (now_n),
		.long_press (long_press_q),
		.mode_idx   (mode_idx_q),
		.profile_idx(profile_idx_q),
		.mode_sel   (mode_sel),
		.profile_sel(profile_sel),
		.gate       (gate)
	);

	assign out_valid     = valid_s2;
	assign press_events  = events_s2;
	assign combo_event   = combo_s2;
	assign stable_levels = levels_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled while the pipeline could move");

	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(now_q))
		else $error("time advanced without a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("tick transfer lost its result");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && gate.tracking |-> fire == '0)
		else $error("press event while combo is tracked");

endmodule
